// File: src/tpsc_pkg.sv
package tpsc_pkg;

  // Field widths of the channels
  localparam int KIND_W   = 3;
  localparam int VIN_W    = 12;
  localparam int PHASE_W  = 3;
  localparam int COEF_W   = 32;
  localparam int TOL_W    = 12;
  localparam int NEED_W   = 4;
  localparam int RUN_W    = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 12;
  localparam int CMP_W    = 17;

  // Event codes
  localparam logic [KIND_W-1:0] KIND_SAMPLE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_START_PH = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START_EC = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADVANCE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CANCEL   = 3'd4;

  // Calibration phases
  localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAIT1   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SETTLE1 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT2   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_SETTLE2 = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE    = 1'b1;

  localparam logic [TOL_W-1:0]  TOL_RST  = 12'd50;
  localparam logic [NEED_W-1:0] NEED_RST = 4'd5;
  localparam logic [RUN_W-1:0]  RUN_MAX  = 4'd15;

  // Stored point reset values in mV (before masking to the voltage width)
  localparam logic [15:0] PH4_RST_MV   = 16'd2000;
  localparam logic [15:0] PH7_RST_MV   = 16'd1500;
  localparam logic [15:0] ECLO_RST_MV  = 16'd1000;
  localparam logic [15:0] ECHI_RST_MV  = 16'd2000;

  // Line fit arithmetic: numerators stay below 2^30, dividend below 2^31
  localparam int NUM_W = 34;
  localparam int DIV_W = 32;
  localparam int CNT_W = $clog2(DIV_W);
  localparam int FRAC_BITS = 16;

  // Reference values: point one y and (y2 - y1)
  localparam logic signed [NUM_W-1:0] PH_Y1  = 34'sd7000;
  localparam logic signed [NUM_W-1:0] PH_DY  = -34'sd3000;
  localparam logic signed [NUM_W-1:0] EC_Y1  = 34'sd1413;
  localparam logic signed [NUM_W-1:0] EC_DY  = 34'sd11467;

  // Coefficient jobs run by the shared divider: bit 1 sensor, bit 0 offset
  localparam logic [1:0] JOB_PH_SLOPE = 2'd0;
  localparam logic [1:0] JOB_PH_OFF   = 2'd1;
  localparam logic [1:0] JOB_EC_SLOPE = 2'd2;
  localparam logic [1:0] JOB_EC_OFF   = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic       apply;
    logic       load;
    logic       step;
    logic       save;
    logic       emit;
    logic [1:0] job;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic store;
    logic out_free;
  } sts_t;

  // One result transaction
  typedef struct packed {
    logic [PHASE_W-1:0]       phase;
    logic                     sensor_is_ec;
    logic signed [COEF_W-1:0] ph_slope;
    logic signed [COEF_W-1:0] ph_offset;
    logic signed [COEF_W-1:0] ec_slope;
    logic signed [COEF_W-1:0] ec_offset;
    logic                     ph_invalid;
    logic                     ec_invalid;
  } res_t;

endpackage

// File: src/tpsc_if.sv
interface tpsc_in_if import tpsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [VIN_W-1:0]  voltage_mv;

  modport source (output valid, kind, voltage_mv, input ready);
  modport sink   (input valid, kind, voltage_mv, output ready);
endinterface

interface tpsc_out_if import tpsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PHASE_W-1:0]       phase;
  logic                     sensor_is_ec;
  logic signed [COEF_W-1:0] ph_slope;
  logic signed [COEF_W-1:0] ph_offset;
  logic signed [COEF_W-1:0] ec_slope;
  logic signed [COEF_W-1:0] ec_offset;
  logic                     ph_invalid;
  logic                     ec_invalid;

  modport source (output valid, phase, sensor_is_ec, ph_slope, ph_offset, ec_slope,
                  ec_offset, ph_invalid, ec_invalid, input ready);
  modport sink   (input valid, phase, sensor_is_ec, ph_slope, ph_offset, ec_slope,
                  ec_offset, ph_invalid, ec_invalid, output ready);
endinterface

interface tpsc_cfg_if import tpsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/two_point_sensor_calibration.sv
// Two-point calibration sequencer for a pH or conductivity probe. Each input
// transaction (sample, start pH, start EC, advance, cancel) produces exactly one
// result transaction carrying the phase, the sensor under calibration and the
// line coefficients of both sensors. The result of an ordinary event is
// registered once the output register is free. An advance that stores new points
// recomputes all four coefficients on one shared restoring divider (load, divide
// and save for each coefficient) before its result is registered. Right after reset the
// divider computes the coefficients of the default points, and
// no input is accepted during that time. One event is processed at a time; a
// new event may be accepted while the previous result waits in the output
// register. Configuration writes are always accepted and must only be issued
// while the block is idle.
module two_point_sensor_calibration import tpsc_pkg::*; #(
  parameter int VOLT_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpsc_in_if.sink     in_i,
  tpsc_out_if.source  out_o,
  tpsc_cfg_if.sink    cfg_i
);

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic out_valid;

  assign cfg_i.ready = 1'b1;

  tpsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tpsc_dp #(
    .VB (VOLT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .kind_i      (in_i.kind),
    .voltage_i   (in_i.voltage_mv),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cmd_i       (cmd),
    .out_ready_i (out_o.ready),
    .sts_o       (sts),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  // Result channel
  assign out_o.valid        = out_valid;
  assign out_o.phase        = res.phase;
  assign out_o.sensor_is_ec = res.sensor_is_ec;
  assign out_o.ph_slope     = res.ph_slope;
  assign out_o.ph_offset    = res.ph_offset;
  assign out_o.ec_slope     = res.ec_slope;
  assign out_o.ec_offset    = res.ec_offset;
  assign out_o.ph_invalid   = res.ph_invalid;
  assign out_o.ec_invalid   = res.ec_invalid;

  // A new result only appears after an emit command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.emit))
    else $error("result valid without emit");

  // A divider load is always followed by a divide step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> cmd.step)
    else $error("load not followed by divide");

  // Only one event in flight: no accept in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second transaction accepted while busy");

endmodule

// File: src/tpsc_ctrl.sv
module tpsc_ctrl import tpsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SAVE = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [1:0]       job_q, job_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pend_q, pend_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.job  = job_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.apply = 1'b1;
          if (sts_i.store) begin
            job_d   = JOB_PH_SLOPE;
            pend_d  = 1'b1;
            state_d = S_LOAD;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d      = '0;
        state_d    = S_DIV;
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_W - 1)) begin
          state_d = S_SAVE;
        end
      end
      S_SAVE: begin
        cmd_o.save = 1'b1;
        if (job_q == JOB_EC_OFF) begin
          pend_d  = 1'b0;
          state_d = pend_q ? S_EMIT : S_IDLE;
        end else begin
          job_d   = job_q + 1'b1;
          state_d = S_LOAD;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // After reset the coefficients of the default points are computed first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      job_q   <= JOB_PH_SLOPE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

endmodule

// File: src/tpsc_dp.sv
module tpsc_dp import tpsc_pkg::*; #(
  parameter int VB = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [VIN_W-1:0]     voltage_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  cmd_t                 cmd_i,
  input  logic                 out_ready_i,
  output sts_t                 sts_o,
  output logic                 out_valid_o,
  output res_t                 res_o
);

  localparam logic [VB-1:0] PH4_RST  = VB'(PH4_RST_MV);
  localparam logic [VB-1:0] PH7_RST  = VB'(PH7_RST_MV);
  localparam logic [VB-1:0] ECLO_RST = VB'(ECLO_RST_MV);
  localparam logic [VB-1:0] ECHI_RST = VB'(ECHI_RST_MV);

  // Configuration
  logic [TOL_W-1:0]  tol_q;
  logic [NEED_W-1:0] need_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TOL_RST;
      need_q <= NEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TOLERANCE: tol_q  <= cfg_data_i[TOL_W-1:0];
        CFG_STABLE:    need_q <= cfg_data_i[NEED_W-1:0];
        default:       ;
      endcase
    end
  end

  // Sequencer state
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               sens_q, sens_d;
  logic [VB-1:0]      prev_q, prev_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic [VB-1:0]      p1_q, p1_d, p2_q, p2_d;
  logic [VB-1:0]      ph4_q, ph4_d, ph7_q, ph7_d, eclo_q, eclo_d, echi_q, echi_d;
  logic [VB-1:0]      v;
  logic [VB-1:0]      diff;
  logic [RUN_W-1:0]   run_n;

  assign v    = VB'(voltage_i);
  assign diff = (v >= prev_q) ? v - prev_q : prev_q - v;
  assign sts_o.store = (kind_i == KIND_ADVANCE) && (phase_q == PH_DONE);

  always_comb begin
    phase_d = phase_q;
    sens_d  = sens_q;
    prev_d  = prev_q;
    run_d   = run_q;
    p1_d    = p1_q;
    p2_d    = p2_q;
    ph4_d   = ph4_q;
    ph7_d   = ph7_q;
    eclo_d  = eclo_q;
    echi_d  = echi_q;
    run_n   = '0;
    if (cmd_i.apply) begin
      case (kind_i)
        KIND_SAMPLE: begin
          if (phase_q == PH_SETTLE1 || phase_q == PH_SETTLE2) begin
            if (CMP_W'(diff) <= CMP_W'(tol_q)) begin
              run_n = (run_q != RUN_MAX) ? run_q + 1'b1 : run_q;
            end
            run_d  = run_n;
            prev_d = v;
            if (run_n >= need_q) begin
              if (phase_q == PH_SETTLE1) begin
                p1_d    = v;
                phase_d = PH_WAIT2;
              end else begin
                p2_d    = v;
                phase_d = PH_DONE;
              end
            end
          end
        end
        KIND_START_PH, KIND_START_EC: begin
          sens_d  = (kind_i == KIND_START_EC);
          phase_d = PH_WAIT1;
          run_d   = '0;
        end
        KIND_ADVANCE: begin
          run_d = '0;
          if (phase_q == PH_WAIT1) begin
            phase_d = PH_SETTLE1;
          end else if (phase_q == PH_WAIT2) begin
            phase_d = PH_SETTLE2;
          end else if (phase_q == PH_DONE) begin
            if (sens_q) begin
              eclo_d = p1_q;
              echi_d = p2_q;
            end else begin
              ph7_d = p1_q;
              ph4_d = p2_q;
            end
            phase_d = PH_IDLE;
          end
        end
        KIND_CANCEL: begin
          phase_d = PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      sens_q  <= 1'b0;
      prev_q  <= '0;
      run_q   <= '0;
      ph4_q   <= PH4_RST;
      ph7_q   <= PH7_RST;
      eclo_q  <= ECLO_RST;
      echi_q  <= ECHI_RST;
    end else begin
      phase_q <= phase_d;
      sens_q  <= sens_d;
      prev_q  <= prev_d;
      run_q   <= run_d;
      ph4_q   <= ph4_d;
      ph7_q   <= ph7_d;
      eclo_q  <= eclo_d;
      echi_q  <= echi_d;
    end
  end

  // Captured points hold data only
  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    p2_q <= p2_d;
  end

  // Numerator and divisor setup for the selected coefficient
  logic [VB-1:0]           x1, x2;
  logic signed [VB:0]      dspan;
  logic signed [NUM_W-1:0] d_ext, x1_ext, y1, dy, num;
  logic [NUM_W-1:0]        num_mag;
  logic [VB-1:0]           d_mag;
  logic [DIV_W-1:0]        dividend;

  always_comb begin
    x1 = cmd_i.job[1] ? eclo_q : ph7_q;
    x2 = cmd_i.job[1] ? echi_q : ph4_q;
    y1 = cmd_i.job[1] ? EC_Y1 : PH_Y1;
    dy = cmd_i.job[1] ? EC_DY : PH_DY;
    dspan  = $signed({1'b0, x2}) - $signed({1'b0, x1});
    d_ext  = NUM_W'(dspan);
    x1_ext = $signed(NUM_W'(x1));
    if (cmd_i.job[0]) begin
      num = y1 * d_ext - dy * x1_ext;
    end else begin
      num = dy <<< FRAC_BITS;
    end
    num_mag  = num[NUM_W-1] ? -num : num;
    d_mag    = dspan[VB] ? VB'(-dspan) : dspan[VB-1:0];
    dividend = num_mag[DIV_W-1:0] + DIV_W'(d_mag >> 1);
  end

  // Restoring divider, one quotient bit per step
  logic [VB-1:0]    ad_q, rem_q;
  logic [DIV_W-1:0] quo_q;
  logic             neg_q, zero_q;
  logic [VB:0]      rem_sh;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, ad_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ad_q   <= d_mag;
      rem_q  <= '0;
      quo_q  <= dividend;
      neg_q  <= num[NUM_W-1] ^ dspan[VB];
      zero_q <= (dspan == '0);
    end else if (cmd_i.step) begin
      rem_q <= fits ? VB'(rem_sh - {1'b0, ad_q}) : rem_sh[VB-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  // Sign and saturation of the quotient
  logic signed [COEF_W-1:0] coef;

  always_comb begin
    if (zero_q) begin
      coef = '0;
    end else if (neg_q) begin
      coef = (quo_q > {1'b1, {(DIV_W-1){1'b0}}}) ? {1'b1, {(COEF_W-1){1'b0}}}
                                                : COEF_W'(-quo_q);
    end else begin
      coef = quo_q[DIV_W-1] ? {1'b0, {(COEF_W-1){1'b1}}} : COEF_W'(quo_q);
    end
  end

  // Coefficient registers
  logic signed [COEF_W-1:0] ph_slope_q, ph_off_q, ec_slope_q, ec_off_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.save) begin
      case (cmd_i.job)
        JOB_PH_SLOPE: ph_slope_q <= coef;
        JOB_PH_OFF:   ph_off_q   <= coef;
        JOB_EC_SLOPE: ec_slope_q <= coef;
        JOB_EC_OFF:   ec_off_q   <= coef;
        default:      ;
      endcase
    end
  end

  // Output register
  logic out_valid_q;
  res_t res_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.phase        <= phase_q;
      res_q.sensor_is_ec <= sens_q;
      res_q.ph_slope     <= ph_slope_q;
      res_q.ph_offset    <= ph_off_q;
      res_q.ec_slope     <= ec_slope_q;
      res_q.ec_offset    <= ec_off_q;
      res_q.ph_invalid   <= (ph7_q == ph4_q);
      res_q.ec_invalid   <= (eclo_q == echi_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// File: sim/two_point_sensor_calibration_tb.sv
module two_point_sensor_calibration_tb;
  import tpsc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Kinds with no defined action
  localparam logic [KIND_W-1:0] KIND_RSVD5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

  // Reference points: milli-pH and uS/cm
  localparam longint PH7_MPH  = 7000;
  localparam longint PH4_MPH  = 4000;
  localparam longint EC_LO_US = 1413;
  localparam longint EC_HI_US = 12880;

  localparam int MV_MAX      = 4095;
  localparam int PHASE_ITEMS = 355;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [VIN_W-1:0]  mv;
    bit                typed;
    res_t              want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tpsc_in_if  in_if ();
  tpsc_out_if out_if ();
  tpsc_cfg_if cfg_if ();

  two_point_sensor_calibration dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mirror of the calibration state
  logic [TOL_W-1:0]   tol_reg;
  logic [NEED_W-1:0]  need_reg;
  logic [PHASE_W-1:0] exp_phase;
  logic               exp_sensor;
  logic [VIN_W-1:0]   last_mv;
  logic [RUN_W-1:0]   run_len;
  logic [VIN_W-1:0]   cap1_mv;
  logic [VIN_W-1:0]   cap2_mv;
  logic [VIN_W-1:0]   ph4_pt;
  logic [VIN_W-1:0]   ph7_pt;
  logic [VIN_W-1:0]   eclo_pt;
  logic [VIN_W-1:0]   echi_pt;

  res_t        result_q[$];
  dir_row_t    dir_q[$];
  int          err_cnt   = 0;
  int          item_cnt  = 0;
  int          src_burst = 0;
  int          snk_burst = 0;
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Wait length per transaction, with occasional back-to-back stretches
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(15, 60);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Quotient rounded to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    bit     neg;
    longint an;
    longint ad;
    longint q;
    neg = (num < 0) != (den < 0);
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    q   = (an + ad / 2) / ad;
    return neg ? -q : q;
  endfunction

  function automatic logic signed [COEF_W-1:0] clamp32(longint val);
    if (val > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (val < -64'sd2147483648) return 32'sh80000000;
    return val[COEF_W-1:0];
  endfunction

  // Line through (x1,y1),(x2,y2): Q16.16 slope and integer intercept
  task automatic fit_line(input logic [VIN_W-1:0] x1, input longint y1,
                          input logic [VIN_W-1:0] x2, input longint y2,
                          output logic signed [COEF_W-1:0] slope,
                          output logic signed [COEF_W-1:0] offset,
                          output logic inv);
    longint d;
    longint dy;
    d  = longint'(x2) - longint'(x1);
    dy = y2 - y1;
    if (d == 0) begin
      slope  = '0;
      offset = '0;
      inv    = 1'b1;
    end else begin
      slope  = clamp32(round_div(dy * 65536, d));
      offset = clamp32(round_div(y1 * d - dy * longint'(x1), d));
      inv    = 1'b0;
    end
  endtask

  // Advance the mirrored state by one event and form its result
  task automatic predict_event(input logic [KIND_W-1:0] k, input logic [VIN_W-1:0] v,
                               output res_t r);
    logic [VIN_W-1:0] diff;
    case (k)
      KIND_SAMPLE: begin
        if (exp_phase == PH_SETTLE1 || exp_phase == PH_SETTLE2) begin
          diff = (v >= last_mv) ? v - last_mv : last_mv - v;
          if (diff <= tol_reg) begin
            if (run_len < RUN_MAX) run_len++;
          end else begin
            run_len = '0;
          end
          last_mv = v;
          if (run_len >= need_reg) begin
            if (exp_phase == PH_SETTLE1) begin
              cap1_mv   = v;
              exp_phase = PH_WAIT2;
            end else begin
              cap2_mv   = v;
              exp_phase = PH_DONE;
            end
          end
        end
      end
      KIND_START_PH, KIND_START_EC: begin
        exp_sensor = (k == KIND_START_EC);
        exp_phase  = PH_WAIT1;
        run_len    = '0;
      end
      KIND_ADVANCE: begin
        run_len = '0;
        case (exp_phase)
          PH_WAIT1: exp_phase = PH_SETTLE1;
          PH_WAIT2: exp_phase = PH_SETTLE2;
          PH_DONE: begin
            if (exp_sensor) begin
              eclo_pt = cap1_mv;
              echi_pt = cap2_mv;
            end else begin
              ph7_pt = cap1_mv;
              ph4_pt = cap2_mv;
            end
            exp_phase = PH_IDLE;
          end
          default: ;
        endcase
      end
      KIND_CANCEL: exp_phase = PH_IDLE;
      default: ;
    endcase
    r.phase        = exp_phase;
    r.sensor_is_ec = exp_sensor;
    fit_line(ph7_pt, PH7_MPH, ph4_pt, PH4_MPH, r.ph_slope, r.ph_offset, r.ph_invalid);
    fit_line(eclo_pt, EC_LO_US, echi_pt, EC_HI_US, r.ec_slope, r.ec_offset, r.ec_invalid);
  endtask

  // Drive one event transaction; queue its expected result on acceptance
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [VIN_W-1:0] mv,
                           input bit typed = 1'b0, input res_t want = '0);
    int   gap;
    res_t r;
    gap = draw_wait(src_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= k;
    in_if.voltage_mv <= mv;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_event(k, mv, r);
    result_q.push_back(typed ? want : r);
    item_cnt++;
  endtask

  task automatic drain(input int extra);
    in_if.valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_config(input int tol, input int need);
    drain(8);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_TOLERANCE;
    cfg_if.data  <= CFG_DAT_W'(tol);
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.index <= CFG_STABLE;
    cfg_if.data  <= CFG_DAT_W'(need);
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    tol_reg  = TOL_W'(tol);
    need_reg = NEED_W'(need);
  endtask

  task automatic add_row(input logic [KIND_W-1:0] k, input logic [VIN_W-1:0] mv,
                         input bit typed, input res_t want);
    dir_row_t row;
    row.kind  = k;
    row.mv    = mv;
    row.typed = typed;
    row.want  = want;
    dir_q.push_back(row);
  endtask

  function automatic int pick_base();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? MV_MAX : 0;
    return $urandom_range(0, MV_MAX);
  endfunction

  // Samples around a base voltage until the point is captured or given up on
  task automatic settle_point(input int base, input bit exact);
    int amp;
    int val;
    amp = exact ? 0 : int'(tol_reg) / 2;
    for (int n = 0; n < 80; n++) begin
      if (exp_phase != PH_SETTLE1 && exp_phase != PH_SETTLE2) return;
      if ($urandom_range(0, 39) == 0) begin
        send_item(KIND_CANCEL, VIN_W'($urandom_range(0, MV_MAX)));
        return;
      end
      if ($urandom_range(0, 29) == 0) begin
        send_item(KIND_ADVANCE, VIN_W'($urandom_range(0, MV_MAX)));
      end else begin
        if ($urandom_range(0, 14) == 0)
          val = $urandom_range(0, MV_MAX);
        else
          val = base + int'($urandom_range(0, 2 * amp)) - amp;
        if (val < 0) val = 0;
        if (val > MV_MAX) val = MV_MAX;
        send_item(KIND_SAMPLE, VIN_W'(val));
      end
    end
  endtask

  // One calibration sequence, sometimes broken off or disturbed
  task automatic run_calibration();
    bit same;
    send_item($urandom_range(0, 1) ? KIND_START_EC : KIND_START_PH,
              VIN_W'($urandom_range(0, MV_MAX)));
    if ($urandom_range(0, 9) == 0)
      send_item(KIND_SAMPLE, VIN_W'($urandom_range(0, MV_MAX)));
    if ($urandom_range(0, 19) == 0)
      send_item(KIND_START_PH, VIN_W'($urandom_range(0, MV_MAX)));
    send_item(KIND_ADVANCE, VIN_W'($urandom_range(0, MV_MAX)));
    settle_point(pick_base(), 1'b0);
    if (exp_phase != PH_WAIT2) return;
    if ($urandom_range(0, 9) == 0)
      send_item(KIND_SAMPLE, VIN_W'($urandom_range(0, MV_MAX)));
    send_item(KIND_ADVANCE, VIN_W'($urandom_range(0, MV_MAX)));
    // equal points now and then exercise the zero-span case
    same = ($urandom_range(0, 7) == 0);
    settle_point(same ? int'(cap1_mv) : pick_base(), same);
    if (exp_phase != PH_DONE) return;
    if ($urandom_range(0, 9) == 0)
      send_item(KIND_SAMPLE, VIN_W'($urandom_range(0, MV_MAX)));
    if ($urandom_range(0, 14) == 0) begin
      send_item(KIND_CANCEL, VIN_W'($urandom_range(0, MV_MAX)));
      return;
    end
    if ($urandom_range(0, 19) == 0) begin
      send_item(KIND_START_EC, VIN_W'($urandom_range(0, MV_MAX)));
      return;
    end
    send_item(KIND_ADVANCE, VIN_W'($urandom_range(0, MV_MAX)));
  endtask

  function automatic void check_field(string fname, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      err_cnt++;
    end
  endfunction

  // Result sink with random stalls; compares each transaction in order
  initial begin
    int   stall;
    res_t want;
    res_t got;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_wait(snk_burst);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      got.phase        = out_if.phase;
      got.sensor_is_ec = out_if.sensor_is_ec;
      got.ph_slope     = out_if.ph_slope;
      got.ph_offset    = out_if.ph_offset;
      got.ec_slope     = out_if.ec_slope;
      got.ec_offset    = out_if.ec_offset;
      got.ph_invalid   = out_if.ph_invalid;
      got.ec_invalid   = out_if.ec_invalid;
      if (result_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        err_cnt++;
      end else begin
        want = result_q.pop_front();
        check_field("phase", want.phase, got.phase);
        check_field("sensor_is_ec", want.sensor_is_ec, got.sensor_is_ec);
        check_field("ph_slope", want.ph_slope, got.ph_slope);
        check_field("ph_offset", want.ph_offset, got.ph_offset);
        check_field("ec_slope", want.ec_slope, got.ec_slope);
        check_field("ec_offset", want.ec_offset, got.ec_offset);
        check_field("ph_invalid", want.ph_invalid, got.ph_invalid);
        check_field("ec_invalid", want.ec_invalid, got.ec_invalid);
      end
    end
  end

  // Stimulus: directed table, then random phases under several settings
  initial begin
    res_t dflt;
    res_t ph_flat;
    int   tol_set[5];
    int   need_set[5];
    int   target;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = KIND_SAMPLE;
    in_if.voltage_mv  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_TOLERANCE;
    cfg_if.data       = '0;

    tol_reg    = TOL_RST;
    need_reg   = NEED_RST;
    exp_phase  = PH_IDLE;
    exp_sensor = 1'b0;
    last_mv    = '0;
    run_len    = '0;
    cap1_mv    = '0;
    cap2_mv    = '0;
    ph4_pt     = 12'd2000;
    ph7_pt     = 12'd1500;
    eclo_pt    = 12'd1000;
    echi_pt    = 12'd2000;

    // Default points: pH 1500/2000 mV, EC 1000/2000 mV
    dflt.phase        = PH_IDLE;
    dflt.sensor_is_ec = 1'b0;
    dflt.ph_slope     = -32'sd393216;
    dflt.ph_offset    = 32'sd16000;
    dflt.ec_slope     = 32'sd751501;
    dflt.ec_offset    = -32'sd10054;
    dflt.ph_invalid   = 1'b0;
    dflt.ec_invalid   = 1'b0;
    ph_flat            = dflt;
    ph_flat.ph_slope   = '0;
    ph_flat.ph_offset  = '0;
    ph_flat.ph_invalid = 1'b1;

    // Idle no-ops, reserved kinds, then a pH run that stores equal points
    add_row(KIND_CANCEL, 12'd0, 1'b1, dflt);
    add_row(KIND_RSVD5, 12'd0, 1'b1, dflt);
    add_row(KIND_RSVD6, 12'hAAA, 1'b1, dflt);
    add_row(KIND_RSVD7, 12'hFFF, 1'b1, dflt);
    add_row(KIND_SAMPLE, 12'hFFF, 1'b1, dflt);
    add_row(KIND_ADVANCE, 12'd0, 1'b1, dflt);
    add_row(KIND_START_EC, 12'h555, 1'b0, dflt);
    add_row(KIND_START_PH, 12'd0, 1'b0, dflt);
    add_row(KIND_ADVANCE, 12'd0, 1'b0, dflt);
    add_row(KIND_SAMPLE, 12'd0, 1'b0, dflt);
    repeat (4) add_row(KIND_SAMPLE, 12'hFFF, 1'b0, dflt);
    add_row(KIND_ADVANCE, 12'd0, 1'b0, dflt);
    repeat (5) add_row(KIND_SAMPLE, 12'hFFF, 1'b0, dflt);
    add_row(KIND_ADVANCE, 12'd0, 1'b0, dflt);
    repeat (5) add_row(KIND_SAMPLE, 12'hFFF, 1'b0, dflt);
    add_row(KIND_ADVANCE, 12'd0, 1'b1, ph_flat);

    tol_set  = '{0, 4095, 30, $urandom_range(5, 200), $urandom_range(0, 4095)};
    need_set = '{0, 15, 1, $urandom_range(2, 8), $urandom_range(0, 15)};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_q[i]) send_item(dir_q[i].kind, dir_q[i].mv, dir_q[i].typed, dir_q[i].want);

    for (int p = 0; p < 5; p++) begin
      set_config(tol_set[p], need_set[p]);
      target = item_cnt + PHASE_ITEMS;
      while (item_cnt < target) begin
        if ($urandom_range(0, 99) < 85)
          run_calibration();
        else
          send_item(KIND_W'($urandom_range(0, 7)), VIN_W'($urandom_range(0, MV_MAX)));
      end
    end

    drain(150);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
